[hw/rtl/pdf_pkg.sv]
// Shared widths, the body record type, the dipole constant and the saturating
// force adder for the pairwise dipole force block.
// No dependencies.
package pdf_pkg;

  localparam int MAX_BODIES = 64;
  localparam int ADDR_W     = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  localparam int POS_W   = 24;
  localparam int MOM_W   = 16;
  localparam int ID_W    = 16;
  localparam int IDX_W   = 6;
  localparam int FORCE_W = 48;

  localparam int DIFF_W = POS_W + 1;
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int R2_W   = SQ_W + 1;
  localparam int ROOT_W = R2_W / 2;
  localparam int R2SQ_W = 2 * R2_W;
  localparam int PM_W   = 2 * MOM_W;
  localparam int K_W    = 27;
  localparam int KP_W   = K_W + PM_W;

  localparam int MUL_A_W = R2SQ_W;
  localparam int MUL_B_W = 56;
  localparam int DIG_W   = 8;
  localparam int MUL_STEPS = MUL_B_W / DIG_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int NUM_SH = 16;
  localparam int NUM_W  = KP_W + DIFF_W + NUM_SH;
  localparam int DEN_W  = R2SQ_W + ROOT_W - 1;
  localparam int Q_W    = FORCE_W - 1;

  // 3e-7 in units of 2^-48, rounded to nearest.
  localparam logic [K_W-1:0] DIPOLE_K = K_W'(84442493);

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [MOM_W-1:0] moment;
    logic             magnetic;
    logic [ID_W-1:0]  ident;
  } body_t;

  function automatic logic signed [FORCE_W-1:0] sat_add(
    input logic signed [FORCE_W-1:0] a,
    input logic signed [FORCE_W-1:0] b
  );
    logic [FORCE_W:0] s;
    s = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      sat_add = s[FORCE_W] ? FORCE_MIN : FORCE_MAX;
    end else begin
      sat_add = s[FORCE_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/pairwise_dipole_force_unit.sv]
// Bodies load one word per cycle while idle; after the last body the force accumulators
// are cleared, then each interacting pair runs 25 root steps, four multiplies and a
// divide; skipped and coincident pairs are passed over, and the forces then stream out.
// Throughput: one set at a time; the shared multiplier and dividers set the pace.
// Reset (synchronous, rst_n low) empties the set and idles the block.
module pairwise_dipole_force_unit import pdf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [POS_W-1:0]   in_pos_x,
  input  logic signed [POS_W-1:0]   in_pos_y,
  input  logic [MOM_W-1:0]          in_moment,
  input  logic                      in_is_magnetic,
  input  logic [ID_W-1:0]           in_body_id,
  input  logic                      in_last_body,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_body_index,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  output logic                      out_last_force
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_LDI_RD   = 5'd2;
  localparam logic [4:0] S_LDI_CAP  = 5'd3;
  localparam logic [4:0] S_LDJ_RD   = 5'd4;
  localparam logic [4:0] S_LDJ_CAP  = 5'd5;
  localparam logic [4:0] S_SQ       = 5'd6;
  localparam logic [4:0] S_R2       = 5'd7;
  localparam logic [4:0] S_SQRT     = 5'd8;
  localparam logic [4:0] S_MUL_GO   = 5'd9;
  localparam logic [4:0] S_MUL_WAIT = 5'd10;
  localparam logic [4:0] S_DIV_GO   = 5'd11;
  localparam logic [4:0] S_DIV_WAIT = 5'd12;
  localparam logic [4:0] S_ACC_RI   = 5'd13;
  localparam logic [4:0] S_ACC_WI   = 5'd14;
  localparam logic [4:0] S_ACC_RJ   = 5'd15;
  localparam logic [4:0] S_ACC_WJ   = 5'd16;
  localparam logic [4:0] S_NEXT     = 5'd17;
  localparam logic [4:0] S_OUT_RD   = 5'd18;
  localparam logic [4:0] S_OUT_LD   = 5'd19;
  localparam logic [4:0] S_OUT_WAIT = 5'd20;

  // Multiply sequence for one pair.
  localparam logic [1:0] MOP_SQ  = 2'd0;
  localparam logic [1:0] MOP_DEN = 2'd1;
  localparam logic [1:0] MOP_NX  = 2'd2;
  localparam logic [1:0] MOP_NY  = 2'd3;

  localparam int SQC_W = $clog2(ROOT_W);

  // Control state.
  logic [4:0]        state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  j_r;
  logic [CNT_W-1:0]  k_r;
  logic [1:0]        mop_r;
  logic [SQC_W-1:0]  sq_cnt_r;
  logic              dxd_r;
  logic              dyd_r;
  logic              out_valid_r;

  // Body store and force accumulators, each one synchronous memory.
  body_t                  bmem [MAX_BODIES];
  body_t                  brd_r;
  logic [ADDR_W-1:0]      baddr;
  logic                   bwe;
  logic [2*FORCE_W-1:0]   amem [MAX_BODIES];
  logic [2*FORCE_W-1:0]   ard_r;
  logic [ADDR_W-1:0]      aaddr;
  logic [ADDR_W-1:0]      awaddr;
  logic                   awe;
  logic [2*FORCE_W-1:0]   awdata;
  logic signed [FORCE_W-1:0] ard_fx;
  logic signed [FORCE_W-1:0] ard_fy;

  // Pair datapath.
  body_t                      bi_r;
  logic signed [DIFF_W-1:0]   dx_r;
  logic signed [DIFF_W-1:0]   dy_r;
  logic [PM_W-1:0]            pm_r;
  logic [SQ_W-1:0]            dxsq_r;
  logic [SQ_W-1:0]            dysq_r;
  logic [KP_W-1:0]            kp_r;
  logic [R2_W-1:0]            r2_r;
  logic [R2_W-1:0]            sq_x_r;
  logic [R2_W-1:0]            sq_res_r;
  logic [R2_W-1:0]            sq_bit_r;
  logic [R2SQ_W-1:0]          r2sq_r;
  logic [DEN_W-1:0]           den_r;
  logic [NUM_W-1:0]           numx_r;
  logic [NUM_W-1:0]           numy_r;
  logic signed [FORCE_W-1:0]  fx_r;
  logic signed [FORCE_W-1:0]  fy_r;

  logic signed [2*DIFF_W-1:0] dxsq_full;
  logic signed [2*DIFF_W-1:0] dysq_full;
  logic [R2_W-1:0]            r2_sum;
  logic [R2_W:0]              sq_trial;
  logic                       sq_take;
  logic [DIFF_W-1:0]          magx;
  logic [DIFF_W-1:0]          magy;

  logic                       in_acc;
  logic [CNT_W-1:0]           count_after;
  logic [CNT_W:0]             i_plus2;
  logic [CNT_W:0]             j_plus1;
  logic                       pair_skip;

  // Output word registers.
  logic [IDX_W-1:0]           out_idx_r;
  logic signed [FORCE_W-1:0]  out_fx_r;
  logic signed [FORCE_W-1:0]  out_fy_r;
  logic                       out_last_r;

  // Shared units.
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start;
  logic               divx_done;
  logic               divy_done;
  logic [Q_W-1:0]     qx;
  logic [Q_W-1:0]     qy;
  logic               divx_fin;
  logic               divy_fin;

  // Bodies are only taken while idle; a body beyond the store depth is
  // dropped but its last-body mark still starts the computation.
  assign in_ready    = (state_r == S_IDLE);
  assign in_acc      = in_valid && in_ready;
  assign bwe         = in_acc && (count_r < CNT_W'(MAX_BODIES));
  assign count_after = bwe ? count_r + CNT_W'(1) : count_r;

  assign i_plus2 = {1'b0, i_r} + (CNT_W+1)'(2);
  assign j_plus1 = {1'b0, j_r} + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[count_r[ADDR_W-1:0]] <= '{x: in_pos_x, y: in_pos_y, moment: in_moment,
                                     magnetic: in_is_magnetic, ident: in_body_id};
    end
    brd_r <= bmem[baddr];
  end

  assign baddr = (state_r == S_LDJ_RD) ? j_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];

  // A pair takes part only when both bodies are magnetic and their
  // identifiers differ.
  assign pair_skip = !brd_r.magnetic || (brd_r.ident == bi_r.ident);

  assign ard_fx = $signed(ard_r[FORCE_W-1:0]);
  assign ard_fy = $signed(ard_r[2*FORCE_W-1:FORCE_W]);

  always_comb begin
    aaddr  = k_r[ADDR_W-1:0];
    awaddr = k_r[ADDR_W-1:0];
    awe    = 1'b0;
    awdata = '0;
    case (state_r)
      S_CLR: begin
        awe = 1'b1;
      end
      S_ACC_RI: begin
        aaddr = i_r[ADDR_W-1:0];
      end
      S_ACC_WI: begin
        awaddr = i_r[ADDR_W-1:0];
        awe    = 1'b1;
        awdata = {sat_add(ard_fy, -fy_r), sat_add(ard_fx, -fx_r)};
      end
      S_ACC_RJ: begin
        aaddr = j_r[ADDR_W-1:0];
      end
      S_ACC_WJ: begin
        awaddr = j_r[ADDR_W-1:0];
        awe    = 1'b1;
        awdata = {sat_add(ard_fy, fy_r), sat_add(ard_fx, fx_r)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (awe) begin
      amem[awaddr] <= awdata;
    end
    ard_r <= amem[aaddr];
  end

  // Squares, distance and one bit per cycle of the integer square root.
  assign dxsq_full = dx_r * dx_r;
  assign dysq_full = dy_r * dy_r;
  assign r2_sum    = {1'b0, dxsq_r} + {1'b0, dysq_r};
  assign sq_trial  = {1'b0, sq_res_r} + {1'b0, sq_bit_r};
  assign sq_take   = {1'b0, sq_x_r} >= sq_trial;
  assign magx      = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign magy      = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);

  // The multiplier runs r2*r2, then r2^2*root, then kp*|dx| and kp*|dy|.
  always_comb begin
    case (mop_r)
      MOP_SQ: begin
        mul_a = MUL_A_W'(r2_r);
        mul_b = MUL_B_W'(r2_r);
      end
      MOP_DEN: begin
        mul_a = MUL_A_W'(r2sq_r);
        mul_b = MUL_B_W'(sq_res_r[ROOT_W-1:0]);
      end
      MOP_NX: begin
        mul_a = MUL_A_W'(kp_r);
        mul_b = MUL_B_W'(magx);
      end
      default: begin
        mul_a = MUL_A_W'(kp_r);
        mul_b = MUL_B_W'(magy);
      end
    endcase
  end

  assign mul_start = (state_r == S_MUL_GO);
  assign div_start = (state_r == S_DIV_GO);
  assign divx_fin  = dxd_r || divx_done;
  assign divy_fin  = dyd_r || divy_done;

  pdf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  pdf_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numx_r),
    .den   (den_r),
    .done  (divx_done),
    .q     (qx)
  );

  pdf_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (numy_r),
    .den   (den_r),
    .done  (divy_done),
    .q     (qy)
  );

  // Sequencer: load, clear, walk the pairs i<j, then stream the forces.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      mop_r       <= MOP_SQ;
      sq_cnt_r    <= '0;
      dxd_r       <= 1'b0;
      dyd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            count_r <= count_after;
            if (in_last_body) begin
              n_r     <= count_after;
              k_r     <= '0;
              state_r <= S_CLR;
            end
          end
        end
        S_CLR: begin
          if (k_r + CNT_W'(1) == n_r) begin
            k_r <= '0;
            i_r <= '0;
            j_r <= CNT_W'(1);
            state_r <= (n_r < CNT_W'(2)) ? S_OUT_RD : S_LDI_RD;
          end else begin
            k_r <= k_r + CNT_W'(1);
          end
        end
        S_LDI_RD: begin
          state_r <= S_LDI_CAP;
        end
        S_LDI_CAP: begin
          if (brd_r.magnetic) begin
            state_r <= S_LDJ_RD;
          end else if (i_plus2 < {1'b0, n_r}) begin
            i_r     <= i_r + CNT_W'(1);
            j_r     <= i_plus2[CNT_W-1:0];
            state_r <= S_LDI_RD;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        S_LDJ_RD: begin
          state_r <= S_LDJ_CAP;
        end
        S_LDJ_CAP: begin
          state_r <= pair_skip ? S_NEXT : S_SQ;
        end
        S_SQ: begin
          state_r <= S_R2;
        end
        S_R2: begin
          sq_cnt_r <= '0;
          state_r  <= (r2_sum == '0) ? S_NEXT : S_SQRT;
        end
        S_SQRT: begin
          sq_cnt_r <= sq_cnt_r + SQC_W'(1);
          if (sq_cnt_r == SQC_W'(ROOT_W - 1)) begin
            mop_r   <= MOP_SQ;
            state_r <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state_r <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (mop_r == MOP_NY) begin
              state_r <= S_DIV_GO;
            end else begin
              mop_r   <= mop_r + 2'd1;
              state_r <= S_MUL_GO;
            end
          end
        end
        S_DIV_GO: begin
          dxd_r   <= 1'b0;
          dyd_r   <= 1'b0;
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          dxd_r <= divx_fin;
          dyd_r <= divy_fin;
          if (divx_fin && divy_fin) begin
            state_r <= S_ACC_RI;
          end
        end
        S_ACC_RI: begin
          state_r <= S_ACC_WI;
        end
        S_ACC_WI: begin
          state_r <= S_ACC_RJ;
        end
        S_ACC_RJ: begin
          state_r <= S_ACC_WJ;
        end
        S_ACC_WJ: begin
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (j_plus1 < {1'b0, n_r}) begin
            j_r     <= j_plus1[CNT_W-1:0];
            state_r <= S_LDJ_RD;
          end else if (i_plus2 < {1'b0, n_r}) begin
            i_r     <= i_r + CNT_W'(1);
            j_r     <= i_plus2[CNT_W-1:0];
            state_r <= S_LDI_RD;
          end else begin
            state_r <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              count_r <= '0;
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + CNT_W'(1);
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, loaded by state.
  always_ff @(posedge clk) begin
    case (state_r)
      S_LDI_CAP: begin
        bi_r <= brd_r;
      end
      S_LDJ_CAP: begin
        dx_r <= $signed({brd_r.x[POS_W-1], brd_r.x}) - $signed({bi_r.x[POS_W-1], bi_r.x});
        dy_r <= $signed({brd_r.y[POS_W-1], brd_r.y}) - $signed({bi_r.y[POS_W-1], bi_r.y});
        pm_r <= {{MOM_W{1'b0}}, bi_r.moment} * {{MOM_W{1'b0}}, brd_r.moment};
      end
      S_SQ: begin
        dxsq_r <= dxsq_full[SQ_W-1:0];
        dysq_r <= dysq_full[SQ_W-1:0];
        kp_r   <= {{(KP_W-K_W){1'b0}}, DIPOLE_K} * {{(KP_W-PM_W){1'b0}}, pm_r};
      end
      S_R2: begin
        r2_r     <= r2_sum;
        sq_x_r   <= r2_sum;
        sq_res_r <= '0;
        sq_bit_r <= {2'b01, {(R2_W-2){1'b0}}};
      end
      S_SQRT: begin
        if (sq_take) begin
          sq_x_r   <= sq_x_r - sq_trial[R2_W-1:0];
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_MUL_WAIT: begin
        if (mul_done) begin
          case (mop_r)
            MOP_SQ:  r2sq_r <= mul_p[R2SQ_W-1:0];
            MOP_DEN: den_r  <= mul_p[DEN_W-1:0];
            MOP_NX:  numx_r <= {mul_p[NUM_W-NUM_SH-1:0], {NUM_SH{1'b0}}};
            default: numy_r <= {mul_p[NUM_W-NUM_SH-1:0], {NUM_SH{1'b0}}};
          endcase
        end
      end
      S_DIV_WAIT: begin
        fx_r <= dx_r[DIFF_W-1] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        fy_r <= dy_r[DIFF_W-1] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      end
      S_OUT_LD: begin
        out_idx_r  <= k_r[IDX_W-1:0];
        out_fx_r   <= ard_fx;
        out_fy_r   <= ard_fy;
        out_last_r <= (k_r + CNT_W'(1) == n_r);
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_body_index = out_idx_r;
  assign out_force_x    = out_fx_r;
  assign out_force_y    = out_fy_r;
  assign out_last_force = out_last_r;

endmodule

[hw/rtl/pdf_mul.sv]
// Digit-serial unsigned multiplier: one 8-bit digit of b per cycle.
// Depends on pdf_pkg.
module pdf_mul import pdf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] p
);

  localparam int STEP_W = $clog2(MUL_STEPS + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [STEP_W-1:0]          step_r;
  logic [MUL_A_W-1:0]         a_r;
  logic [MUL_B_W-1:0]         b_r;
  logic [MUL_A_W-1:0]         hi_r;
  logic [MUL_B_W-1:0]         lo_r;
  logic [MUL_A_W+DIG_W-1:0]   part;

  assign part = {{DIG_W{1'b0}}, hi_r} +
                ({{DIG_W{1'b0}}, a_r} * {{MUL_A_W{1'b0}}, b_r[DIG_W-1:0]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      hi_r <= '0;
      lo_r <= '0;
    end else if (busy_r) begin
      lo_r <= {part[DIG_W-1:0], lo_r[MUL_B_W-1:DIG_W]};
      hi_r <= part[MUL_A_W+DIG_W-1:DIG_W];
      b_r  <= b_r >> DIG_W;
    end
  end

  assign done = done_r;
  assign p    = {hi_r, lo_r};

endmodule

[hw/rtl/pdf_div.sv]
// Restoring divider, one quotient bit per cycle, saturating to 2^47-1.
// Depends on pdf_pkg.
module pdf_div import pdf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   q
);

  localparam int SH_W  = DEN_W + Q_W;
  localparam int CNT_B = $clog2(Q_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_B-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [SH_W-1:0]  dsh_r;
  logic [Q_W-1:0]   q_r;
  logic             sat;
  logic             ge;

  // A quotient of 2^47 or more clips at once.
  assign sat = {{(SH_W-NUM_W){1'b0}}, num} >= {den, {Q_W{1'b0}}};
  assign ge  = {{(SH_W-NUM_W){1'b0}}, rem_r} >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (sat) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_B'(1);
        if (cnt_r == CNT_B'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {1'b0, den, {(Q_W-1){1'b0}}};
      q_r   <= sat ? {Q_W{1'b1}} : '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r[NUM_W-1:0];
      end
      q_r   <= {q_r[Q_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

[hw/rtl/pdf_checker.sv]
// Port-level checks for the pairwise dipole force unit, bound to its top level.
// Depends on pdf_pkg and pairwise_dipole_force_unit.
module pdf_checker import pdf_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_last_body,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [IDX_W-1:0]          out_body_index,
  input logic signed [FORCE_W-1:0] out_force_x,
  input logic                      out_last_force
);

  // Loading and streaming never overlap.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input ready while a force word is offered");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_force_x) &&
                                $stable(out_body_index))
    else $error("stalled force word changed");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_body |=> !in_ready)
    else $error("input still ready after the last body");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_force |=> in_ready)
    else $error("block not idle after the final force word");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_force |=> !out_valid && !in_ready)
    else $error("force stream ended early");

endmodule

bind pairwise_dipole_force_unit pdf_checker u_pdf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_body   (in_last_body),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_body_index (out_body_index),
  .out_force_x    (out_force_x),
  .out_last_force (out_last_force)
);

[verif/pairwise_dipole_force_checker.sv]
// Checker for the pairwise dipole force unit: watches the body and force channels,
// predicts the net forces of each set and compares them field by field.
// Depends on pdf_pkg for widths and the set size.
module pairwise_dipole_force_checker import pdf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic signed [POS_W-1:0]   in_pos_x,
  input  logic signed [POS_W-1:0]   in_pos_y,
  input  logic [MOM_W-1:0]          in_moment,
  input  logic                      in_is_magnetic,
  input  logic [ID_W-1:0]           in_body_id,
  input  logic                      in_last_body,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [IDX_W-1:0]          out_body_index,
  input  logic signed [FORCE_W-1:0] out_force_x,
  input  logic signed [FORCE_W-1:0] out_force_y,
  input  logic                      out_last_force,
  output int                        fail_count,
  output int                        forces_pending,
  output int                        forces_seen
);

  typedef struct {
    logic [IDX_W-1:0] index;
    longint           fx;
    longint           fy;
    logic             last;
  } net_force_t;

  localparam longint F_MAX = 64'sd140737488355327;
  localparam longint F_MIN = -64'sd140737488355328;

  longint     set_x [MAX_BODIES];
  longint     set_y [MAX_BODIES];
  longint     set_mom [MAX_BODIES];
  logic       set_mag [MAX_BODIES];
  logic [ID_W-1:0] set_id [MAX_BODIES];
  longint     net_fx [MAX_BODIES];
  longint     net_fy [MAX_BODIES];
  int         set_size;
  net_force_t force_queue[$];

  assign forces_pending = force_queue.size();

  function automatic longint clamp_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > F_MAX) return F_MAX;
    if (s < F_MIN) return F_MIN;
    return s;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // One axis of a pair force: K*P*|d|*2^16 / (r2*r2*R), exact, then clamped.
  function automatic longint axis_force(logic [63:0] kp, longint d, logic [159:0] den);
    logic [159:0] num, q;
    longint       mag;
    mag = (d < 0) ? -d : d;
    num = {96'd0, kp} * ({96'd0, mag[63:0]} << 16);
    q = num / den;
    if (q > 160'(F_MAX)) q = 160'(F_MAX);
    return (d < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic predict_set_forces();
    longint dx, dy, r2, root, fx, fy;
    logic [159:0] den;
    logic [63:0]  kp;
    net_force_t   nf;
    for (int k = 0; k < MAX_BODIES; k++) begin
      net_fx[k] = 0;
      net_fy[k] = 0;
    end
    for (int i = 0; i < set_size; i++) begin
      if (!set_mag[i]) continue;
      for (int j = i + 1; j < set_size; j++) begin
        if (!set_mag[j] || set_id[i] == set_id[j]) continue;
        dx = set_x[j] - set_x[i];
        dy = set_y[j] - set_y[i];
        r2 = dx * dx + dy * dy;
        // Coincident bodies would divide by zero, so the pair is left out.
        if (r2 == 0) continue;
        root = floor_root(r2);
        den = 160'(r2) * 160'(r2) * 160'(root);
        kp = 64'(DIPOLE_K) * 64'(set_mom[i] * set_mom[j]);
        fx = axis_force(kp, dx, den);
        fy = axis_force(kp, dy, den);
        net_fx[i] = clamp_add(net_fx[i], -fx);
        net_fy[i] = clamp_add(net_fy[i], -fy);
        net_fx[j] = clamp_add(net_fx[j], fx);
        net_fy[j] = clamp_add(net_fy[j], fy);
      end
    end
    for (int k = 0; k < set_size; k++) begin
      nf.index = k[IDX_W-1:0];
      nf.fx = net_fx[k];
      nf.fy = net_fy[k];
      nf.last = (k + 1 == set_size);
      force_queue = {force_queue, nf};
    end
    set_size = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at force %0d: %s got %0d, expected %0d", forces_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (set_size < MAX_BODIES) begin
        set_x[set_size] = longint'(in_pos_x);
        set_y[set_size] = longint'(in_pos_y);
        set_mom[set_size] = longint'(in_moment);
        set_mag[set_size] = in_is_magnetic;
        set_id[set_size] = in_body_id;
        set_size++;
      end
      if (in_last_body) predict_set_forces();
    end
    if (rst_n && out_valid && out_ready) begin
      net_force_t want;
      if (force_queue.size() == 0) begin
        $display("unexpected force word, index %0d", out_body_index);
        fail_count++;
      end else begin
        want = force_queue.pop_front();
        if (out_body_index != want.index)
          report_mismatch("body_index", out_body_index, want.index);
        if (out_force_x != want.fx[FORCE_W-1:0])
          report_mismatch("force_x", longint'(out_force_x), want.fx);
        if (out_force_y != want.fy[FORCE_W-1:0])
          report_mismatch("force_y", longint'(out_force_y), want.fy);
        if (out_last_force != want.last)
          report_mismatch("last_force", out_last_force, want.last);
      end
      forces_seen++;
    end
  end

endmodule

[verif/pairwise_dipole_force_unit_test.sv]
// Top of the pairwise dipole force testbench: clock, reset, body stimulus,
// receiver stalls and the verdict. Depends on pdf_pkg, the unit and its checker.
module pairwise_dipole_force_unit_test;
  import pdf_pkg::*;

  // Slowest set is a full 64-body set under heavy receiver stalls;
  // the limit leaves plenty of room over that.
  localparam int CYCLE_LIMIT = 4000000;
  localparam int RANDOM_BODIES = 285;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [POS_W-1:0]   in_pos_x;
  logic signed [POS_W-1:0]   in_pos_y;
  logic [MOM_W-1:0]          in_moment;
  logic                      in_is_magnetic;
  logic [ID_W-1:0]           in_body_id;
  logic                      in_last_body;
  logic                      out_valid;
  logic                      out_ready;
  logic [IDX_W-1:0]          out_body_index;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic                      out_last_force;

  int fail_count;
  int forces_pending;
  int forces_seen;
  int cycle_count;
  int burst_left;
  int bodies_sent;
  int sets_sent;

  pairwise_dipole_force_unit i_dut (.*);

  pairwise_dipole_force_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // The watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver cycles through four stall styles in turn: always ready, coin
  // flips, ready a quarter of the time, and mostly ready.
  always @(negedge clk) begin
    case ((cycle_count / 97) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (cycle_count % 4 == 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 9) < 8);
      end
    endcase
  end

  // Sends one body word. The sender works in bursts; when a burst runs out, valid
  // drops for a random gap before the next word. Some bursts are long enough to
  // give stretches without any gap at all.
  task automatic send_body(logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [MOM_W-1:0] m,
                           logic mag, logic [ID_W-1:0] id, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_moment <= m;
    in_is_magnetic <= mag;
    in_body_id <= id;
    in_last_body <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bodies_sent++;
    if (last) sets_sent++;
  endtask

  task automatic drain_forces();
    in_valid <= 1'b0;
    while (forces_pending != 0) @(negedge clk);
  endtask

  // A random set. Most bodies sit in a cluster so that forces are moderate and
  // accumulate; some take full-range positions. On average half the identifiers
  // come from a small pool so that equal identifiers show up.
  task automatic send_random_set(int size);
    logic [POS_W-1:0] cx, cy, x, y;
    logic [ID_W-1:0]  id;
    logic             noisy;
    noisy = ($urandom_range(0, 9) == 0);
    cx = POS_W'($urandom_range(0, 2097151) - 1048576);
    cy = POS_W'($urandom_range(0, 2097151) - 1048576);
    for (int k = 0; k < size; k++) begin
      if (noisy || $urandom_range(0, 3) == 0) begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
      end else begin
        x = POS_W'(cx + $urandom_range(0, 4095) - 2048);
        y = POS_W'(cy + $urandom_range(0, 4095) - 2048);
      end
      id = ID_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom);
      send_body(x, y, MOM_W'($urandom),
                noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 6) != 0),
                id, k == size - 1);
    end
  endtask

  initial begin
    int size, left;
    burst_left = 0;
    bodies_sent = 0;
    sets_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_moment = '0;
    in_is_magnetic = 1'b0;
    in_body_id = '0;
    in_last_body = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed set: a neighbor one LSB away with full moments saturates, a body
    // coincident with the first is skipped, an equal identifier is skipped, a
    // non-magnetic body and a zero moment add nothing, and the far corners of the
    // position range meet.
    send_body(24'h000000, 24'h000000, 16'hFFFF, 1'b1, 16'h0001, 1'b0);
    send_body(24'h000001, 24'h000000, 16'hFFFF, 1'b1, 16'h0002, 1'b0);
    send_body(24'h000000, 24'h000000, 16'hFFFF, 1'b1, 16'h0003, 1'b0);
    send_body(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b1, 16'h0001, 1'b0);
    send_body(24'h000000, 24'h000001, 16'hFFFF, 1'b0, 16'h0004, 1'b0);
    send_body(24'h000000, 24'hFFFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0);
    send_body(24'h000010, 24'h000010, 16'h0000, 1'b1, 16'h0005, 1'b0);
    send_body(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b1, 16'h0006, 1'b0);
    send_body(24'h800000, 24'h800000, 16'h0001, 1'b1, 16'h0000, 1'b1);
    // A set of one body has no pairs.
    send_body(24'h123456, 24'hABCDEF, 16'h8000, 1'b1, 16'h0007, 1'b1);
    // Two clustered bodies far from the origin with a modest separation.
    send_body(24'h400000, 24'hC00000, 16'h0100, 1'b1, 16'h0008, 1'b0);
    send_body(24'h400400, 24'hC00300, 16'h0200, 1'b1, 16'h0009, 1'b1);

    // Hold off until every expected force has come back.
    drain_forces();

    // Overflow: 66 bodies; the last two are dropped, the last one still starts the
    // computation. Also exercises every body index.
    for (int k = 0; k < 66; k++) begin
      send_body(24'(k * 300 - 9000), 24'(($urandom_range(0, 255) - 128) * 40),
                MOM_W'($urandom), ($urandom_range(0, 7) != 0), 16'(k), k == 65);
    end
    drain_forces();

    left = RANDOM_BODIES;
    while (left > 0) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      if (size > left) size = left;
      send_random_set(size);
      left -= size;
      if ($urandom_range(0, 11) == 0) drain_forces();
    end

    drain_forces();
    repeat (500) @(negedge clk);

    $display("Ran %0d body words in %0d sets and checked %0d force words,",
             bodies_sent, sets_sent, forces_seen);
    $display("covering saturation, coincident and same-id pairs, and set overflow.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pdf_pkg.sv
hw/rtl/pdf_mul.sv
hw/rtl/pdf_div.sv
hw/rtl/pairwise_dipole_force_unit.sv
hw/rtl/pdf_checker.sv
verif/pairwise_dipole_force_checker.sv
verif/pairwise_dipole_force_unit_test.sv
